>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge out of reset.
`define DEP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Expression must never be true at a rising edge out of reset.
`define DEP_NEVER(name, expr, msg) \
    `DEP_ASSERT(name, !(expr), msg)

`endif

>>> hw/rtl/dep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dep_pkg
// Shared widths, character codes and divider types for the decimal parser.
// ----------------------------------------------------------------------------
package dep_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int LEN_W   = 6;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
    localparam logic [CHAR_W-1:0] CH_ESC       = 8'd27;
    localparam logic [CHAR_W-1:0] CH_PLUS      = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS     = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE      = 8'd57;

    // Divide-by-ten unit: long division, one 16-bit digit per cycle
    localparam int DIV_CHUNK_W = 16;
    localparam int DIV_STEPS   = VALUE_W / DIV_CHUNK_W;
    localparam int DIV_STEP_W  = 2;
    localparam int DIV_REM_W   = 4;
    localparam int DIV_NUM_W   = DIV_REM_W + DIV_CHUNK_W;
    localparam int DIV_RECIP_W = 15;
    localparam int DIV_SHIFT   = 18;
    // floor(2^18 / 10): estimate is low by at most one
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 15'd26214;
    localparam logic [DIV_NUM_W-1:0]   DIV_TEN   = 20'd10;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } div_ctrl_t;

    typedef struct packed {
        logic idle;
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/dep_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dep_channels
// Valid/ready channels for character items and parse result items.
// ----------------------------------------------------------------------------
interface dep_char_if import dep_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface dep_result_if import dep_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] number_value;
    logic [LEN_W-1:0]          entry_length;
    logic                      parse_error;

    modport source (output valid, output number_value, output entry_length,
                    output parse_error, input ready);
    modport sink   (input valid, input number_value, input entry_length,
                    input parse_error, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/decimal_entry_parser_with_backspace.sv
`default_nettype none
// A terminator is held in the input register, then its result is loaded into the output register.
// One character per cycle while the output slot is free; a backspace that removes a digit holds the
//   processing stage until the divide-by-ten unit (16 bits per cycle) is done.
// The output register parts the two sides: while a result waits, the input register can still take one character.
// Reset (rst_n low, asynchronous) clears the value, entry count, sign flags and valids.
// ----------------------------------------------------------------------------
// decimal_entry_parser_with_backspace
// Builds a signed decimal number from a character stream with backspace
// editing; a terminator emits the value and entry length.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_entry_parser_with_backspace import dep_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    dep_char_if.sink     chars,
    dep_result_if.source result
);

    localparam logic [LEN_W-1:0] MaxEntries = LEN_W'(MAX_ENTRIES);

    // Input register: one character item waiting for the processing stage
    logic              hold_valid_reg;
    logic [CHAR_W-1:0] char_reg;

    // Parser state
    logic [VALUE_W-1:0] accum_reg, accum_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic               sign_first_reg, sign_first_next;
    logic               neg_reg, neg_next;

    // Output register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic               out_err_reg;

    // Character classes of the held item
    logic is_term, is_sign, is_digit, is_bs;
    logic sign_only;
    logic needs_div;
    logic out_free;
    logic fire;

    logic               emit;
    logic [VALUE_W-1:0] emit_value;
    logic [LEN_W-1:0]   emit_len;
    logic               emit_err;

    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    logic [VALUE_W-1:0] div_quot;

    always_comb
    begin
        is_term  = char_reg inside {CH_NUL, CH_LF, CH_CR, CH_ESC};
        is_sign  = char_reg inside {CH_PLUS, CH_MINUS};
        is_digit = char_reg inside {[CH_ZERO:CH_NINE]};
        is_bs    = (char_reg == CH_BACKSPACE);
    end

    // The only held entry is the sign: backspace just drops it
    assign sign_only = (count_reg == LEN_W'(1)) && sign_first_reg;

    // Backspace over a digit waits for the divider
    assign needs_div = hold_valid_reg && is_bs && (count_reg != '0) && !sign_only;

    // Processing stage fires when the output slot can take a result and any needed divide is done
    assign out_free    = !out_valid_reg || result.ready;
    assign fire        = hold_valid_reg && out_free && (!needs_div || div_stat.done);
    assign chars.ready = !hold_valid_reg || fire;

    assign div_ctrl.start = needs_div && div_stat.idle;
    assign div_ctrl.ack   = fire && needs_div;

    dep_div10 u_div10
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (accum_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Next parser state and result for the held character
    always_comb
    begin
        accum_next      = accum_reg;
        count_next      = count_reg;
        sign_first_next = sign_first_reg;
        neg_next        = neg_reg;
        emit            = 1'b0;
        emit_value      = '0;
        emit_len        = '0;
        emit_err        = 1'b0;

        if (fire)
        begin
            if (is_term)
            begin
                // Emit the signed value; a minus sign counts twice in the length
                emit       = 1'b1;
                emit_value = neg_reg ? (~accum_reg + VALUE_W'(1)) : accum_reg;
                emit_len   = count_reg + LEN_W'(neg_reg);
            end
            else if (is_sign && (count_reg == '0))
            begin
                sign_first_next = 1'b1;
                neg_next        = (char_reg == CH_MINUS);
                count_next      = count_reg + LEN_W'(1);
            end
            else if (is_digit)
            begin
                if (count_reg >= MaxEntries)
                begin
                    // History full: reject the entry
                    emit     = 1'b1;
                    emit_err = 1'b1;
                end
                else
                begin
                    // value*10 + digit, wrapping
                    accum_next = (accum_reg << 3) + (accum_reg << 1)
                               + VALUE_W'(char_reg[3:0]);
                    count_next = count_reg + LEN_W'(1);
                end
            end
            else if (is_bs)
            begin
                if (count_reg == '0)
                begin
                    // Nothing to remove: reject
                    emit     = 1'b1;
                    emit_err = 1'b1;
                end
                else if (sign_only)
                begin
                    sign_first_next = 1'b0;
                    neg_next        = 1'b0;
                    count_next      = count_reg - LEN_W'(1);
                end
                else
                begin
                    accum_next = div_quot;
                    count_next = count_reg - LEN_W'(1);
                end
            end

            // Clear the entry after every result
            if (emit)
            begin
                accum_next      = '0;
                count_next      = '0;
                sign_first_next = 1'b0;
                neg_next        = 1'b0;
            end
        end
    end

    // Control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            accum_reg      <= '0;
            count_reg      <= '0;
            sign_first_reg <= 1'b0;
            neg_reg        <= 1'b0;
        end
        else
        begin
            if (chars.ready)
            begin
                hold_valid_reg <= chars.valid;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            accum_reg      <= accum_next;
            count_reg      <= count_next;
            sign_first_reg <= sign_first_next;
            neg_reg        <= neg_next;
        end
    end

    // Payload registers: load on accept / emit, hold otherwise
    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            char_reg <= chars.char_code;
        end
        if (emit)
        begin
            out_value_reg <= emit_value;
            out_len_reg   <= emit_len;
            out_err_reg   <= emit_err;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.number_value = out_value_reg;
    assign result.entry_length = out_len_reg;
    assign result.parse_error  = out_err_reg;

    // Entry history never grows past its limit
    `DEP_ASSERT(a_count_limit, count_reg <= MaxEntries, "entry count beyond limit")
    // A rejected entry carries a zero value and zero length
    `DEP_ASSERT(a_err_payload, (out_valid_reg && out_err_reg) |-> ((out_value_reg == '0) && (out_len_reg == '0)), "error result with payload")
    // A minus flag only exists with a held sign entry
    `DEP_NEVER(a_neg_without_sign, neg_reg && (!sign_first_reg || (count_reg == '0)), "minus flag without sign entry")
    // Value holds while the divider works on it
    `DEP_ASSERT(a_accum_hold, div_stat.busy |=> $stable(accum_reg), "value changed during divide")

endmodule
`default_nettype wire

>>> hw/rtl/dep_div10.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dep_div10
// Signed 64-bit divide by ten, truncating toward zero, 16 bits per cycle.
// ----------------------------------------------------------------------------
module dep_div10 import dep_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_ctrl_t          ctrl,
    input  logic [VALUE_W-1:0] dividend,
    output div_stat_t          stat,
    output logic [VALUE_W-1:0] quotient
);

    div_state_t              state_reg, state_next;
    logic [DIV_STEP_W-1:0]   step_reg, step_next;
    logic [VALUE_W-1:0]      mag_reg, mag_next;
    logic [DIV_REM_W-1:0]    rem_reg, rem_next;
    logic                    neg_reg, neg_next;

    logic [DIV_NUM_W-1:0]              num;
    logic [DIV_NUM_W+DIV_RECIP_W-1:0]  prod;
    logic [DIV_CHUNK_W-1:0]            q_est;
    logic [DIV_NUM_W-1:0]              r_est;
    logic [DIV_CHUNK_W-1:0]            q_digit;
    logic [DIV_NUM_W-1:0]              r_digit;

    // One long-division digit: estimate by reciprocal, fix up once
    always_comb
    begin
        num   = {rem_reg, mag_reg[VALUE_W-1 -: DIV_CHUNK_W]};
        prod  = DIV_NUM_W'(num) * DIV_RECIP;
        q_est = prod[DIV_SHIFT +: DIV_CHUNK_W];
        r_est = num - (DIV_NUM_W'(q_est) << 3) - (DIV_NUM_W'(q_est) << 1);
        if (r_est >= DIV_TEN)
        begin
            q_digit = q_est + DIV_CHUNK_W'(1);
            r_digit = r_est - DIV_TEN;
        end
        else
        begin
            q_digit = q_est;
            r_digit = r_est;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                step_next = '0;
                if (ctrl.start)
                begin
                    state_next = DIV_RUN;
                    neg_next   = dividend[VALUE_W-1];
                    mag_next   = dividend[VALUE_W-1] ? (~dividend + VALUE_W'(1)) : dividend;
                    rem_next   = '0;
                end
            end
            DIV_RUN:
            begin
                mag_next  = {mag_reg[VALUE_W-DIV_CHUNK_W-1:0], q_digit};
                rem_next  = r_digit[DIV_REM_W-1:0];
                step_next = step_reg + DIV_STEP_W'(1);
                if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign stat.idle = (state_reg == DIV_IDLE);
    assign stat.busy = (state_reg == DIV_RUN);
    assign stat.done = (state_reg == DIV_DONE);
    assign quotient  = neg_reg ? (~mag_reg + VALUE_W'(1)) : mag_reg;

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives character items into the decimal entry parser and checks every
// result item against a cycle-free predictor of the parse: sign entry, digit
// accumulation with 64-bit wrap, backspace editing, history limit, and the
// four terminators. Both channels idle at random; one phase holds the result
// side off long enough to fill the block and stall its character input.
// ----------------------------------------------------------------------------
module testbench;
    import dep_pkg::*;

    localparam int MAX_ENTRIES  = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [LEN_W-1:0]          len;
        logic                      err;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n;

    dep_char_if   char_ch ();
    dep_result_if result_ch ();

    decimal_entry_parser_with_backspace #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (char_ch),
        .result(result_ch)
    );

    always #6 clk = ~clk;

    // Predictor state: mirrors what the block holds between terminators.
    logic [VALUE_W-1:0] acc_value   = '0;
    int unsigned        held_count  = 0;
    bit                 sign_first  = 1'b0;
    bit                 minus_sign  = 1'b0;

    parse_result_t pending_results[$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int chars_sent    = 0;

    // Sender idling: bursts of random length, gaps of random length bounded by gap_max.
    int burst_left    = 0;
    int gap_max       = 0;

    // Receiver idling: 0 none, 1 light, 2 heavy; hold_request asks a long hold-off.
    int stall_level   = 0;
    int hold_request  = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit is_terminator(input logic [CHAR_W-1:0] c);
        return c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_ESC;
    endfunction

    function automatic void clear_entry();
        acc_value  = '0;
        held_count = 0;
        sign_first = 1'b0;
        minus_sign = 1'b0;
    endfunction

    function automatic void push_result(input logic [VALUE_W-1:0] value,
                                        input int unsigned len, input bit err);
        parse_result_t r;
        r.value = value;
        r.len   = len[LEN_W-1:0];
        r.err   = err;
        pending_results.push_back(r);
        clear_entry();
    endfunction

    // Advance the parse by one accepted character; queue a result if it causes one.
    function automatic void parse_char(input logic [CHAR_W-1:0] c);
        if (is_terminator(c)) begin
            if (minus_sign)
                push_result(64'd0 - acc_value, held_count + 1, 1'b0);
            else
                push_result(acc_value, held_count, 1'b0);
        end
        else if ((c == CH_PLUS || c == CH_MINUS) && held_count == 0) begin
            // Only the very first entry can be a sign; later ones fall through
            // to the ignored case below.
            sign_first = 1'b1;
            minus_sign = (c == CH_MINUS);
            held_count = 1;
        end
        else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (held_count >= MAX_ENTRIES)
                push_result('0, 0, 1'b1);
            else begin
                acc_value  = acc_value * 64'd10 + VALUE_W'(c - CH_ZERO);
                held_count = held_count + 1;
            end
        end
        else if (c == CH_BACKSPACE) begin
            if (held_count == 0)
                push_result('0, 0, 1'b1);
            else begin
                if (held_count == 1 && sign_first) begin
                    sign_first = 1'b0;
                    minus_sign = 1'b0;
                end
                else
                    // Signed divide truncates toward zero, on the wrapped bits.
                    acc_value = $signed(acc_value) / 64'sd10;
                held_count = held_count - 1;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // Offer one item and hold it until taken; valid stays high within a burst.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                char_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left = burst_left - 1;
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        do
            @(posedge clk);
        while (!char_ch.ready);
        parse_char(c);
        chars_sent = chars_sent + 1;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++)
            send_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    endtask

    // Drop valid and pause until every queued result has come back.
    task automatic wait_for_results();
        char_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: a 16-bit stall mask, reloaded each time the phase wraps
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] stall_mask;
        int          phase;
        int          hold;
        stall_mask = '0;
        phase      = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            if (phase == 0) begin
                case (stall_level)
                    0:       stall_mask = '0;
                    1:       stall_mask = 16'($urandom() & $urandom());
                    default: stall_mask = 16'($urandom() | $urandom());
                endcase
            end
            result_ch.ready <= !stall_mask[phase];
            phase = (phase + 1) % 16;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what,
                                   input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk) begin
        parse_result_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result item", result_ch.number_value, '0);
            else begin
                want = pending_results.pop_front();
                if (result_ch.number_value !== want.value)
                    report_mismatch("number_value", result_ch.number_value, want.value);
                if (result_ch.entry_length !== want.len)
                    report_mismatch("entry_length", VALUE_W'(result_ch.entry_length),
                                    VALUE_W'(want.len));
                if (result_ch.parse_error !== want.err)
                    report_mismatch("parse_error", VALUE_W'(result_ch.parse_error),
                                    VALUE_W'(want.err));
            end
        end
    end

    // Hang guard
    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Each terminator, including on an empty entry and on a bare sign.
    task automatic test_terminators();
        send_text("12");
        send_char(CH_LF);
        send_text("-3");
        send_char(CH_CR);
        send_char(CH_ESC);
        send_char(CH_PLUS);
        send_char(CH_NUL);
    endtask

    // A sign only counts as the first entry; a later one is ignored.
    task automatic test_sign_rules();
        send_text("5-3+");
        send_char(CH_LF);
        send_text("--");
        send_char(CH_CR);
    endtask

    // Backspace removes digits, then the sign, then errors on an empty entry.
    task automatic test_backspace();
        send_char(CH_BACKSPACE);
        send_text("-45");
        repeat (4) send_char(CH_BACKSPACE);
        send_text("-");
        send_char(CH_BACKSPACE);
        send_text("7");
        send_char(CH_LF);
    endtask

    // Codes outside the parse alphabet, top bit included, leave the entry alone.
    task automatic test_ignored();
        send_text("1a");
        send_char(8'hFF);
        send_char(8'h80);
        send_text(" 2");
        send_char(CH_ESC);
    endtask

    // Nineteen nines set the top bit, so backspace divides a negative number;
    // twenty nines wrap back to a positive one.
    task automatic test_wrapping();
        repeat (19) send_char(CH_NINE);
        send_char(CH_BACKSPACE);
        send_char(CH_LF);
        send_char(CH_MINUS);
        repeat (20) send_char(CH_NINE);
        send_char(CH_BACKSPACE);
        send_char(CH_NUL);
    endtask

    // Fill the history to the limit, then one entry more.
    task automatic test_history_limit();
        send_char(CH_MINUS);
        send_digits(MAX_ENTRIES - 1);
        send_char(CH_LF);
        send_digits(MAX_ENTRIES);
        send_char(CH_BACKSPACE);
        send_char(CH_NINE);
        send_char(CH_ZERO);
        send_char(CH_CR);
    endtask

    // One line: optional sign, digits with edits and noise, then a terminator.
    task automatic send_random_line();
        int ndigits;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // Broken input: raw codes of any value, terminators included.
            repeat ($urandom_range(1, 6)) send_char(CHAR_W'($urandom_range(0, 255)));
            return;
        end
        pick = $urandom_range(0, 2);
        if (pick == 1)
            send_char(CH_PLUS);
        else if (pick == 2)
            send_char(CH_MINUS);
        ndigits = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ENTRIES - 3, MAX_ENTRIES + 2)
                                              : $urandom_range(0, 12);
        for (int i = 0; i < ndigits; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                repeat ($urandom_range(1, 3)) send_char(CH_BACKSPACE);
            else if (pick < 16)
                send_char(CHAR_W'($urandom_range(0, 255)));
            else if (pick < 18)
                send_char(($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
            send_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 4)) send_char(CH_BACKSPACE);
        case ($urandom_range(0, 3))
            0:       send_char(CH_NUL);
            1:       send_char(CH_LF);
            2:       send_char(CH_CR);
            default: send_char(CH_ESC);
        endcase
    endtask

    // Random lines, stepping through idle settings on both sides.
    task automatic test_random_lines();
        int start;
        int lines;
        start = chars_sent;
        lines = 0;
        while (chars_sent - start < RANDOM_ITEMS) begin
            if (lines % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_max = 0;
                    1:       gap_max = 3;
                    default: gap_max = 10;
                endcase
                stall_level = $urandom_range(0, 2);
            end
            send_random_line();
            lines = lines + 1;
        end
    endtask

    // Hold the receiver off while short lines keep coming, so the block fills
    // and stalls its character input.
    task automatic test_backpressure();
        gap_max     = 0;
        stall_level = 0;
        hold_request = 300;
        repeat (60) begin
            send_digits($urandom_range(1, 3));
            send_char(CH_LF);
        end
        wait_for_results();
    endtask

    // The sender pauses until every result is back, then resumes.
    task automatic test_drain_pause();
        gap_max     = 4;
        stall_level = 1;
        repeat (10) send_random_line();
        wait_for_results();
        repeat (10) send_random_line();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n             <= 1'b0;
        char_ch.valid     <= 1'b0;
        char_ch.char_code <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_terminators();
        test_sign_rules();
        test_backspace();
        test_ignored();
        test_wrapping();
        test_history_limit();
        test_backpressure();
        test_drain_pause();
        test_random_lines();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
